// ===== src/internal_chain_hash_table_core_assert.svh =====
// assertion macros for the hash table core
`ifndef INTERNAL_CHAIN_HASH_TABLE_CORE_ASSERT_SVH
`define INTERNAL_CHAIN_HASH_TABLE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ICHT_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ICHT_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) else $error(msg);
`else
`define ICHT_ASSERT(label, clk, rstn, prop, msg)
`define ICHT_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

// ===== src/icht_pkg.sv =====
// ----------------------------------------------------------------------------
// icht_pkg
// types and constants shared by the hash table core and its slot memory
// ----------------------------------------------------------------------------
package icht_pkg;
  localparam int Slots     = 1024;
  localparam int IdxBits   = 10;
  localparam int LinkBits  = 11;
  localparam int KeyBits   = 32;
  localparam int ValueBits = 32;
  localparam int CountBits = 11;

  localparam logic [1:0] CmdAdd    = 2'd0;
  localparam logic [1:0] CmdGet    = 2'd1;
  localparam logic [1:0] CmdCount  = 2'd2;
  localparam logic [1:0] CmdRemove = 2'd3;

  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StMiss    = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;

  localparam logic [LinkBits-1:0] NoneIdx = LinkBits'(Slots);

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key;
    logic [9:0]  home_slot;
    logic [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [10:0] match_count;
    logic [10:0] entry_total;
  } out_word_t;

  // one slot as held in memory
  typedef struct packed {
    logic                used;
    logic [LinkBits-1:0] prev;
    logic [LinkBits-1:0] next;
    logic [KeyBits-1:0]  key;
    logic [ValueBits-1:0] value;
  } slot_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic               rd_en;
    logic [IdxBits-1:0] rd_addr;
    logic               wr_en;
    logic [IdxBits-1:0] wr_addr;
    slot_t              wr_data;
  } mem_req_t;

  function automatic slot_t reset_slot(input logic [IdxBits-1:0] i);
    slot_t s;
    s = '0;
    s.prev = (i == '0) ? NoneIdx : LinkBits'(i) - LinkBits'(1);
    s.next = (32'(i) + 1 < Slots) ? LinkBits'(i) + LinkBits'(1) : NoneIdx;
    return s;
  endfunction
endpackage

// ===== src/icht_slot_ram.sv =====
// ----------------------------------------------------------------------------
// icht_slot_ram
// simple dual port slot store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module icht_slot_ram (
  input  logic              clk_i,
  input  icht_pkg::mem_req_t req_i,
  output icht_pkg::slot_t   rd_data_o
);
  import icht_pkg::*;

  slot_t mem [Slots];

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_o <= mem[req_i.rd_addr];
    end
  end
endmodule

// ===== src/internal_chain_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// internal_chain_hash_table_core
// hash table with chains held inside the slot array and a free slot list
// ----------------------------------------------------------------------------
// Usage: an input word (command, key, home slot, value) is taken on in_valid_i
// while in_stall_o is low; exactly one result word follows on out_valid_o and
// is held until out_stall_i is low. One word is handled at a time.
// Every slot access goes through the slot memory, whose reads are registered;
// the cost per word is set by the dependent reads of the chain.
// Add reads the home slot, claims it when it is free, else pops the free
// head and moves a renter out of the home when needed, then fixes links; get
// and count walk the chain from an owner in the home slot; remove walks as
// get, then unlinks the matching entry and pushes its slot on the free list.
// The next word is taken once the result has left the output register.
// After reset a clearing pass writes every slot, one per cycle, forming one
// free list; in_stall_o is high during the pass.
// When the receiver stalls, the result stays in the output register and the
// next input word waits until it has gone.
// ----------------------------------------------------------------------------
`include "internal_chain_hash_table_core_assert.svh"
module internal_chain_hash_table_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  icht_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output icht_pkg::out_word_t out_data_o
);
  import icht_pkg::*;

  localparam logic [4:0] SClr   = 5'd0;
  localparam logic [4:0] SIdle  = 5'd1;
  localparam logic [4:0] SHome  = 5'd2;  // home slot data arriving
  localparam logic [4:0] SWalk  = 5'd3;  // evaluate chain entry held in cur_q
  localparam logic [4:0] SFree  = 5'd4;  // free head slot data arriving
  localparam logic [4:0] SFNext = 5'd5;  // write home slot
  localparam logic [4:0] SLink  = 5'd6;  // generic neighbour read arriving
  localparam logic [4:0] SWr    = 5'd7;  // run write list
  localparam logic [4:0] SOut   = 5'd8;
  localparam logic [4:0] SRmQ   = 5'd9;  // promoted renter data arriving
  localparam logic [4:0] SPush  = 5'd10; // freed slot pushed on free list

  logic [4:0] state_q, state_d;
  logic [IdxBits-1:0] clr_q, clr_d;
  in_word_t cmd_q, cmd_d;
  slot_t home_q, home_d;     // copy of home slot
  slot_t cur_q, cur_d;       // current work slot
  logic [IdxBits-1:0] cur_idx_q, cur_idx_d;
  logic [LinkBits-1:0] free_head_q, free_head_d;
  logic [CountBits-1:0] count_q, count_d, matches_q, matches_d;
  logic [LinkBits-1:0] steps_q, steps_d;
  out_word_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  // pending link fixes: set next of a, set prev of b and of c (read-modify-write)
  logic fix_a_q, fix_a_d, fix_b_q, fix_b_d, fix_c_q, fix_c_d;
  logic [IdxBits-1:0] a_idx_q, a_idx_d, b_idx_q, b_idx_d, c_idx_q, c_idx_d;
  logic [LinkBits-1:0] a_val_q, a_val_d, b_val_q, b_val_d, c_val_q, c_val_d;
  logic [1:0] fix_sel_q, fix_sel_d; // which fix is reading, 3 for a chain entry read
  logic [1:0] res_q, res_d;
  mem_req_t req;
  slot_t rd;

  icht_slot_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (req),
    .rd_data_o (rd)
  );

  assign in_stall_o  = (state_q != SIdle) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // sequencer
  always_comb begin
    state_d = state_q; clr_d = clr_q; cmd_d = cmd_q; home_d = home_q;
    cur_d = cur_q; cur_idx_d = cur_idx_q; free_head_d = free_head_q;
    count_d = count_q; matches_d = matches_q; steps_d = steps_q;
    out_d = out_q; out_valid_d = out_valid_q;
    fix_a_d = fix_a_q; fix_b_d = fix_b_q; fix_c_d = fix_c_q;
    a_idx_d = a_idx_q; b_idx_d = b_idx_q; c_idx_d = c_idx_q;
    a_val_d = a_val_q; b_val_d = b_val_q; c_val_d = c_val_q;
    fix_sel_d = fix_sel_q; res_d = res_q;
    req = '0;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (state_q)
      SClr: begin
        req.wr_en = 1'b1;
        req.wr_addr = clr_q;
        req.wr_data = reset_slot(clr_q);
        clr_d = clr_q + 1'b1;
        if (clr_q == IdxBits'(Slots - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i && !out_valid_q) begin
          cmd_d = in_data_i;
          req.rd_en = 1'b1;
          req.rd_addr = in_data_i.home_slot;
          matches_d = '0;
          steps_d = '0;
          fix_a_d = 1'b0; fix_b_d = 1'b0; fix_c_d = 1'b0;
          res_d = StMiss;
          state_d = SHome;
        end
      end
      SHome: begin
        home_d = rd;
        cur_d = rd;
        cur_idx_d = cmd_q.home_slot;
        if (cmd_q.command == CmdAdd) begin
          if ({count_q, 1'b0} > (CountBits + 1)'(Slots)) begin
            res_d = StFull; state_d = SOut;
          end else if (!rd.used) begin
            // unlink home from free list and claim it
            req.wr_en = 1'b1;
            req.wr_addr = cmd_q.home_slot;
            req.wr_data = '{1'b1, NoneIdx, NoneIdx, cmd_q.key, cmd_q.value};
            if (rd.prev != NoneIdx) begin
              fix_a_d = 1'b1; a_idx_d = rd.prev[IdxBits-1:0]; a_val_d = rd.next;
            end else free_head_d = rd.next;
            if (rd.next != NoneIdx) begin
              fix_b_d = 1'b1; b_idx_d = rd.next[IdxBits-1:0]; b_val_d = rd.prev;
            end
            res_d = StDone; count_d = count_q + 1'b1;
            state_d = SWr;
          end else if (free_head_q == NoneIdx) begin
            res_d = StFull; state_d = SOut;
          end else begin
            req.rd_en = 1'b1; req.rd_addr = free_head_q[IdxBits-1:0];
            state_d = SFree;
          end
        end else if (rd.used && rd.prev == NoneIdx) begin
          state_d = SWalk; // data already here, evaluate next cycle
          cur_d = rd;
        end else state_d = SOut;
      end
      SFree: begin
        // rd is popped free slot r
        cur_idx_d = free_head_q[IdxBits-1:0];
        free_head_d = rd.next;
        if (rd.next != NoneIdx) begin
          fix_c_d = 1'b1; c_idx_d = rd.next[IdxBits-1:0]; c_val_d = NoneIdx;
        end
        res_d = StDone; count_d = count_q + 1'b1;
        if (home_q.prev != NoneIdx) begin
          // relocate renter to r, claim home
          req.wr_en = 1'b1; req.wr_addr = free_head_q[IdxBits-1:0];
          req.wr_data = '{1'b1, home_q.prev, home_q.next, home_q.key, home_q.value};
          fix_a_d = 1'b1; a_idx_d = home_q.prev[IdxBits-1:0]; a_val_d = free_head_q;
          if (home_q.next != NoneIdx) begin
            fix_b_d = 1'b1; b_idx_d = home_q.next[IdxBits-1:0]; b_val_d = free_head_q;
          end
          cur_d = '{1'b1, NoneIdx, NoneIdx, cmd_q.key, cmd_q.value};
        end else begin
          req.wr_en = 1'b1; req.wr_addr = free_head_q[IdxBits-1:0];
          req.wr_data = '{1'b1, LinkBits'(cmd_q.home_slot), home_q.next,
                          cmd_q.key, cmd_q.value};
          if (home_q.next != NoneIdx) begin
            fix_b_d = 1'b1; b_idx_d = home_q.next[IdxBits-1:0]; b_val_d = free_head_q;
          end
          cur_d = home_q; cur_d.next = free_head_q;
        end
        state_d = SFNext;
      end
      SFNext: begin
        // write home slot
        req.wr_en = 1'b1; req.wr_addr = cmd_q.home_slot; req.wr_data = cur_q;
        state_d = SWr;
      end
      SWalk: begin
        // cur_q holds slot at cur_idx_q
        if (cur_q.used && cur_q.key == cmd_q.key) begin
          if (cmd_q.command == CmdGet) begin
            res_d = StDone; out_d.found_value = cur_q.value; state_d = SOut;
          end else if (cmd_q.command == CmdCount) begin
            matches_d = matches_q + 1'b1;
          end else begin
            res_d = StDone; count_d = count_q - 1'b1;
            if (cur_q.prev != NoneIdx) begin
              // renter: splice out and free
              fix_a_d = 1'b1; a_idx_d = cur_q.prev[IdxBits-1:0]; a_val_d = cur_q.next;
              if (cur_q.next != NoneIdx) begin
                fix_b_d = 1'b1; b_idx_d = cur_q.next[IdxBits-1:0]; b_val_d = cur_q.prev;
              end
              state_d = SPush;
            end else if (cur_q.next != NoneIdx) begin
              req.rd_en = 1'b1; req.rd_addr = cur_q.next[IdxBits-1:0];
              state_d = SRmQ;
            end else begin
              state_d = SPush;
            end
          end
        end
        if (state_d == SWalk) begin
          steps_d = steps_q + 1'b1;
          if (cur_q.next == NoneIdx || steps_q == LinkBits'(Slots - 1)) begin
            if (cmd_q.command == CmdCount && matches_d != '0) res_d = StDone;
            state_d = SOut;
          end else begin
            req.rd_en = 1'b1; req.rd_addr = cur_q.next[IdxBits-1:0];
            cur_idx_d = cur_q.next[IdxBits-1:0];
            state_d = SLink; fix_sel_d = 2'd3;
          end
        end
      end
      SRmQ: begin
        // rd is renter q promoted into home
        req.wr_en = 1'b1; req.wr_addr = cmd_q.home_slot;
        req.wr_data = '{1'b1, NoneIdx, rd.next, rd.key, rd.value};
        if (rd.next != NoneIdx) begin
          fix_b_d = 1'b1; b_idx_d = rd.next[IdxBits-1:0];
          b_val_d = LinkBits'(cmd_q.home_slot);
        end
        cur_idx_d = cur_q.next[IdxBits-1:0];
        state_d = SPush;
      end
      SPush: begin
        // write freed slot, queue a fix of the old free head's prev
        req.wr_en = 1'b1; req.wr_addr = cur_idx_q;
        req.wr_data = '{1'b0, NoneIdx, free_head_q, cmd_q.key, cmd_q.value};
        if (free_head_q != NoneIdx) begin
          fix_c_d = 1'b1; c_idx_d = free_head_q[IdxBits-1:0];
          c_val_d = LinkBits'(cur_idx_q);
        end
        free_head_d = LinkBits'(cur_idx_q);
        state_d = SWr;
      end
      SWr: begin
        // issue reads for pending fixes one at a time
        if (fix_a_q) begin
          req.rd_en = 1'b1; req.rd_addr = a_idx_q; fix_sel_d = 2'd0; state_d = SLink;
        end else if (fix_b_q) begin
          req.rd_en = 1'b1; req.rd_addr = b_idx_q; fix_sel_d = 2'd1; state_d = SLink;
        end else if (fix_c_q) begin
          req.rd_en = 1'b1; req.rd_addr = c_idx_q; fix_sel_d = 2'd2; state_d = SLink;
        end else state_d = SOut;
      end
      SLink: begin
        req.wr_data = rd;
        case (fix_sel_q)
          2'd0: begin
            req.wr_en = 1'b1; req.wr_addr = a_idx_q; req.wr_data.next = a_val_q;
            fix_a_d = 1'b0; state_d = SWr;
          end
          2'd1: begin
            req.wr_en = 1'b1; req.wr_addr = b_idx_q; req.wr_data.prev = b_val_q;
            fix_b_d = 1'b0; state_d = SWr;
          end
          2'd2: begin
            req.wr_en = 1'b1; req.wr_addr = c_idx_q; req.wr_data.prev = c_val_q;
            fix_c_d = 1'b0; state_d = SWr;
          end
          default: begin
            cur_d = rd; state_d = SWalk;
          end
        endcase
      end
      SOut: begin
        out_d.status = res_q;
        if (!(cmd_q.command == CmdGet && res_q == StDone)) out_d.found_value = '0;
        out_d.match_count = (cmd_q.command == CmdCount) ? matches_q : '0;
        out_d.entry_total = count_q;
        out_valid_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr; clr_q <= '0; free_head_q <= '0; count_q <= '0;
      out_valid_q <= 1'b0; fix_a_q <= 1'b0; fix_b_q <= 1'b0; fix_c_q <= 1'b0;
      fix_sel_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; free_head_q <= free_head_d;
      count_q <= count_d; out_valid_q <= out_valid_d;
      fix_a_q <= fix_a_d; fix_b_q <= fix_b_d; fix_c_q <= fix_c_d;
      fix_sel_q <= fix_sel_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; home_q <= home_d; cur_q <= cur_d; cur_idx_q <= cur_idx_d;
    matches_q <= matches_d; steps_q <= steps_d; out_q <= out_d; res_q <= res_d;
    a_idx_q <= a_idx_d; b_idx_q <= b_idx_d; c_idx_q <= c_idx_d;
    a_val_q <= a_val_d; b_val_q <= b_val_d; c_val_q <= c_val_d;
  end

  `ICHT_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CountBits'(Slots), "count overflow")
  `ICHT_ASSERT(a_no_accept_busy, clk_i, rst_ni, !(state_q != SIdle && !in_stall_o), "accept busy")
  `ICHT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")
endmodule
